FILE: hw/rtl/dvrt_pkg.sv
// dvrt_pkg: shared types, codes and constants of the route table engine
// no dependencies
package dvrt_pkg;

    localparam int MaxKnown  = 32;
    localparam int IdxW      = $clog2(MaxKnown);
    localparam int CntW      = $clog2(MaxKnown + 1);
    localparam int ResultCap = 32;

    localparam logic [16:0] CostInf = 17'h1FFFF;
    localparam logic [15:0] CostMax = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_INIT    = 3'd0,
        CMD_ADD_NBR = 3'd1,
        CMD_VECTOR  = 3'd2,
        CMD_TIMEOUT = 3'd3,
        CMD_ADVERT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_ROW  = 2'd2
    } status_t;

    typedef enum logic {
        CFG_OWN_ID = 1'b0,
        CFG_LIMIT  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] peer_id;
        logic [15:0] dest_id;
        logic [16:0] cost_value;
        logic        vector_first;
    } in_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] row_dest;
        logic [16:0] row_cost;
        logic [15:0] row_next_hop;
        logic        renew_timer;
        logic        arm_timer;
        logic        last;
    } out_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_P,
        S_FIND_D,
        S_APPLY,
        S_TIMEOUT,
        S_ADVERT,
        S_EMIT,
        S_DONE
    } state_t;

    // one table row
    typedef struct packed {
        logic [15:0] dest;
        logic [16:0] cost;
        logic [15:0] link;
        logic [15:0] hop;
        logic        down;
    } row_t;

    // sequencer to search unit
    typedef struct packed {
        logic        start;
        logic [15:0] key;
    } srch_ctl_t;

    // search unit status
    typedef struct packed {
        logic            busy;
        logic            done;
        logic            found;
        logic [IdxW-1:0] idx;
    } srch_sts_t;

    // infinity-aware saturating add
    function automatic logic [16:0] add_cost(input logic [15:0] link, input logic [16:0] adv);
        logic [16:0] s;
        s = {1'b0, link} + {1'b0, adv[15:0]};
        if (adv[16])
            return CostInf;
        if (s[16])
            return {1'b0, CostMax};
        return s;
    endfunction

    // a > b, infinity largest
    function automatic logic cost_gt(input logic [16:0] a, input logic [16:0] b);
        if (b[16])
            return 1'b0;
        if (a[16])
            return 1'b1;
        return a[15:0] > b[15:0];
    endfunction

endpackage

FILE: hw/rtl/dvrt_search.sv
// dvrt_search: sequential id search over the table, one entry a cycle
// depends on dvrt_pkg
module dvrt_search
    import dvrt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  srch_ctl_t       ctl,
    input  logic [CntW-1:0] count,
    input  logic [15:0]     rd_dest,
    output logic [IdxW-1:0] rd_idx,
    output srch_sts_t       sts
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            found_reg, found_next;
    logic [CntW-1:0] pos_reg, pos_next;
    logic [15:0]     key_reg, key_next;
    logic [IdxW-1:0] hit_reg, hit_next;

    assign rd_idx = pos_reg[IdxW-1:0];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        hit_next   = hit_reg;
        if (ctl.start)
        begin
            key_next   = ctl.key;
            pos_next   = '0;
            found_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pos_reg >= count)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (rd_dest == key_reg)
            begin
                found_next = 1'b1;
                hit_next   = pos_reg[IdxW-1:0];
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        hit_reg <= hit_next;
    end

    assign sts = '{busy: busy_reg, done: done_reg, found: found_reg, idx: hit_reg};

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("search done while busy");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= count) else $error("search ran past count");
    a_found_lt: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> ({1'b0, hit_reg} < {1'b0, count}))
        else $error("hit beyond table");
`endif

endmodule

FILE: hw/rtl/distance_vector_route_table.sv
// distance_vector_route_table: distance-vector route table with poison reverse
// depends on dvrt_pkg and dvrt_search
//
// channel  | dir | handshake               | payload
// in_*     | in  | in_valid / in_stall     | in_data  (in_req_t)
// out_*    | out | out_valid / out_stall   | out_data (out_req_t)
// cfg_*    | in  | cfg_we                  | cfg_index, cfg_data
//
// one request at a time; a search walks the table one entry per cycle in the
// search unit; vector_entry runs a peer search and then a destination search,
// add_neighbor runs a peer search, and the timeout runs a peer search and then
// walks every row; advertise emits the rows in turn, and init writes the own row
// rst_n clears the count and control; table contents are undefined until init
// out_stall holds the result register; in_stall is high whenever busy, and a
// new request may be taken while the previous result still waits
module distance_vector_route_table
    import dvrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] own_id_reg;
    logic [5:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            limit_reg  <= 6'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_ID: own_id_reg <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // effective limit, capped at table depth and result cap
    localparam int LimCap = (MaxKnown < ResultCap) ? MaxKnown : ResultCap;
    logic [CntW:0] eff_limit;
    always_comb
    begin
        if ({1'b0, limit_reg} > 7'(LimCap))
            eff_limit = (CntW+1)'(LimCap);
        else
            eff_limit = (CntW+1)'(limit_reg);
    end

    // table rows live in a flip-flop array (32 deep, one row per address)
    row_t            tbl [MaxKnown];
    logic [CntW-1:0] count_reg, count_next;

    state_t          state_reg, state_next;
    in_req_t         req_reg;
    logic [CntW-1:0] walk_reg, walk_next;
    logic            p_found_reg;
    logic [IdxW-1:0] p_idx_reg;
    row_t            p_row_reg;
    out_req_t        res_reg, res_next;
    logic            ovalid_reg, ovalid_next;

    // outcome of the applied request, held until the result slot is free
    logic [1:0]      fin_st_reg, fin_st_next;
    logic            fin_renew_reg, fin_renew_next;
    logic            fin_arm_reg, fin_arm_next;

    // write port
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    row_t            wr_row;

    // search unit
    srch_ctl_t       s_ctl;
    srch_sts_t       s_sts;
    logic [IdxW-1:0] s_rd_idx;
    logic [15:0]     s_rd_dest;

    assign s_rd_dest = tbl[s_rd_idx].dest;

    dvrt_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (s_ctl),
        .count   (count_reg),
        .rd_dest (s_rd_dest),
        .rd_idx  (s_rd_idx),
        .sts     (s_sts)
    );

    // read of the row under the walk pointer
    row_t walk_row;
    assign walk_row = tbl[walk_reg[IdxW-1:0]];

    logic [16:0] cval;
    assign cval = req_reg.cost_value[16] ? CostInf : {1'b0, req_reg.cost_value[15:0]};

    logic [15:0] link_v;
    logic [16:0] sum_v;
    assign link_v = p_found_reg ? p_row_reg.link : 16'd0;
    assign sum_v  = add_cost(link_v, cval);

    logic accept_in, take_out;
    assign accept_in = in_valid && !in_stall;
    assign take_out  = ovalid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept_in)
                begin
                    if (in_data.command == CMD_INIT || in_data.command > CMD_ADVERT)
                        state_next = S_DONE;
                    else if (in_data.command == CMD_ADVERT)
                        state_next = S_ADVERT;
                    else
                        state_next = S_FIND_P;
                end
            S_FIND_P:
                if (s_sts.done)
                begin
                    if (req_reg.command == CMD_VECTOR)
                        state_next = S_FIND_D;
                    else if (req_reg.command == CMD_TIMEOUT)
                        state_next = S_TIMEOUT;
                    else
                        state_next = S_APPLY;
                end
            S_FIND_D:
                if (s_sts.done)
                    state_next = S_APPLY;
            S_APPLY:   state_next = S_DONE;
            S_TIMEOUT:
                if (walk_reg >= count_reg)
                    state_next = S_DONE;
            S_ADVERT:
                if (count_reg == '0)
                    state_next = S_DONE;
                else if (!ovalid_reg || take_out)
                    state_next = S_EMIT;
            S_EMIT:
                if (!ovalid_reg || take_out)
                    state_next = (walk_reg + 1'b1 >= count_reg) ? S_IDLE : S_EMIT;
            S_DONE:
                if (!ovalid_reg || take_out)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    logic        p_found_next;
    logic [IdxW-1:0] p_idx_next;
    logic        d_found;
    row_t        d_row, nr;
    logic [1:0]  st_v;
    logic        rearm_v, arm_v;

    always_comb
    begin
        s_ctl          = '{start: 1'b0, key: req_reg.peer_id};
        walk_next      = walk_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_row         = '0;
        res_next       = res_reg;
        ovalid_next    = ovalid_reg && !take_out;
        p_found_next   = p_found_reg;
        p_idx_next     = p_idx_reg;
        fin_st_next    = fin_st_reg;
        fin_renew_next = fin_renew_reg;
        fin_arm_next   = fin_arm_reg;
        d_found        = s_sts.found;
        d_row          = tbl[s_sts.idx];
        nr             = d_row;
        st_v           = ST_DONE;
        rearm_v        = 1'b0;
        arm_v          = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (accept_in)
                begin
                    s_ctl          = '{start: 1'b1, key: in_data.peer_id};
                    walk_next      = '0;
                    fin_st_next    = ST_DONE;
                    fin_renew_next = 1'b0;
                    fin_arm_next   = 1'b0;
                    if (in_data.command == CMD_INIT)
                    begin
                        count_next = CntW'(1);
                        wr_en      = 1'b1;
                        wr_row     = '{dest: own_id_reg, cost: '0, link: '0, hop: '0,
                                       down: 1'b0};
                    end
                end
            S_FIND_P:
                if (s_sts.done)
                begin
                    p_found_next = s_sts.found;
                    p_idx_next   = s_sts.idx;
                    if (req_reg.command == CMD_VECTOR)
                        s_ctl = '{start: 1'b1, key: req_reg.dest_id};
                    if (req_reg.command == CMD_TIMEOUT && s_sts.found)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = s_sts.idx;
                        wr_row = tbl[s_sts.idx];
                        wr_row.down = 1'b1;
                    end
                end
            S_FIND_D:
                ;
            S_APPLY:
                if (req_reg.command == CMD_ADD_NBR)
                begin
                    wr_row = '{dest: req_reg.peer_id,
                               cost: {1'b0, cval[16] ? CostMax : cval[15:0]},
                               link: cval[16] ? CostMax : cval[15:0],
                               hop: req_reg.peer_id, down: 1'b0};
                    if (p_found_reg)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = p_idx_reg;
                    end
                    else if ({1'b0, count_reg} >= eff_limit)
                        st_v = ST_FULL;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = count_reg[IdxW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    fin_st_next = st_v;
                end
                else
                begin
                    rearm_v = req_reg.vector_first && !(p_found_reg && p_row_reg.down);
                    if (!d_found)
                    begin
                        if ({1'b0, count_reg} >= eff_limit)
                            st_v = ST_FULL;
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg[IdxW-1:0];
                            count_next = count_reg + 1'b1;
                            wr_row     = '{dest: req_reg.dest_id, cost: sum_v, link: '0,
                                           hop: cval[16] ? 16'd0 : req_reg.peer_id,
                                           down: 1'b0};
                        end
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_idx = s_sts.idx;
                        if (req_reg.dest_id == req_reg.peer_id)
                        begin
                            if (d_row.down)
                            begin
                                arm_v   = 1'b1;
                                nr.down = 1'b0;
                            end
                            if (d_row.cost[16] || cost_gt(d_row.cost, sum_v))
                            begin
                                nr.cost = {1'b0, d_row.link};
                                nr.hop  = req_reg.peer_id;
                            end
                        end
                        else if (d_row.hop == '0 && d_row.cost[16])
                        begin
                            if (!cval[16])
                            begin
                                nr.hop  = req_reg.peer_id;
                                nr.cost = sum_v;
                            end
                        end
                        else if (d_row.hop != req_reg.peer_id)
                        begin
                            if (!cval[16] && cost_gt(d_row.cost, sum_v))
                            begin
                                nr.hop  = req_reg.peer_id;
                                nr.cost = sum_v;
                            end
                        end
                        else if (!cval[16])
                            nr.cost = sum_v;
                        else
                        begin
                            nr.cost = CostInf;
                            nr.hop  = '0;
                        end
                        wr_row = nr;
                    end
                    fin_st_next    = st_v;
                    fin_renew_next = rearm_v;
                    fin_arm_next   = arm_v;
                end
            S_TIMEOUT:
                if (walk_reg < count_reg)
                begin
                    if (req_reg.peer_id != '0 && walk_row.hop == req_reg.peer_id)
                    begin
                        wr_en       = 1'b1;
                        wr_idx      = walk_reg[IdxW-1:0];
                        wr_row      = walk_row;
                        wr_row.cost = CostInf;
                        wr_row.hop  = '0;
                    end
                    walk_next = walk_reg + 1'b1;
                end
            S_ADVERT:
                walk_next = '0;
            S_EMIT:
                if (!ovalid_reg || take_out)
                begin
                    res_next = '{status: ST_ROW, row_dest: walk_row.dest,
                                 row_cost: (req_reg.peer_id != '0 &&
                                            walk_row.hop == req_reg.peer_id)
                                           ? CostInf : walk_row.cost,
                                 row_next_hop: walk_row.hop, renew_timer: 1'b0,
                                 arm_timer: 1'b0,
                                 last: (walk_reg + 1'b1 >= count_reg)};
                    ovalid_next = 1'b1;
                    walk_next   = walk_reg + 1'b1;
                end
            S_DONE:
                if (!ovalid_reg || take_out)
                begin
                    res_next = '{status: fin_st_reg, row_dest: '0, row_cost: '0,
                                 row_next_hop: '0, renew_timer: fin_renew_reg,
                                 arm_timer: fin_arm_reg, last: 1'b1};
                    ovalid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
            walk_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovalid_reg  <= ovalid_next;
            walk_reg    <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            req_reg <= in_data;
        res_reg       <= res_next;
        p_found_reg   <= p_found_next;
        p_idx_reg     <= p_idx_next;
        fin_st_reg    <= fin_st_next;
        fin_renew_reg <= fin_renew_next;
        fin_arm_reg   <= fin_arm_next;
        if (state_reg == S_FIND_P && s_sts.done)
            p_row_reg <= tbl[s_sts.idx];
        if (wr_en)
            tbl[wr_idx] <= wr_row;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = res_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} <= (CntW+1)'(MaxKnown)) else $error("count overflow");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && out_stall) |=> (ovalid_reg && $stable(res_reg)))
        else $error("stalled result changed");
`endif

endmodule
